@@ sv/arp_rrr_pkg.sv @@
// Shared types and constants for the ARP next-hop resolver.
`default_nettype none

package arp_rrr_pkg;

  localparam int unsigned FRAME_BYTES  = 60;
  localparam int unsigned MAX_TIMEOUTS = 5;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned VID_W    = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned TRY_W    = 3;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_A_W  = 3;
  localparam int unsigned OUT_D_W  = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX_BYTE  = 2'd0,
    KIND_RESOLVED = 2'd1,
    KIND_FAILED   = 2'd2
  } kind_e;

  typedef enum logic [CFG_A_W-1:0] {
    REG_LOCAL_MAC   = 3'd0,
    REG_LOCAL_IP    = 3'd1,
    REG_HOP_IP      = 3'd2,
    REG_VLAN_ENABLE = 3'd3,
    REG_VLAN_ID     = 3'd4,
    REG_BCAST       = 3'd5
  } reg_idx_e;

  localparam logic [BYTE_W-1:0] REQ_HDR [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };
  localparam logic [BYTE_W-1:0] REP_HDR [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  localparam logic [BYTE_W-1:0] VLAN_TPID_HI = 8'h81;
  localparam logic [BYTE_W-1:0] VLAN_TPID_LO = 8'h00;
  localparam logic [MAC_W-1:0]  MAC_ONES     = '1;

  // Byte k of a MAC, most significant first.
  function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] v,
                                                 input logic [2:0] k);
    logic [BYTE_W-1:0] r;
    case (k)
      3'd0:    r = v[47:40];
      3'd1:    r = v[39:32];
      3'd2:    r = v[31:24];
      3'd3:    r = v[23:16];
      3'd4:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  // Byte k of an IPv4 address, most significant first.
  function automatic logic [BYTE_W-1:0] ip_byte(input logic [IP_W-1:0] v,
                                                input logic [1:0] k);
    logic [BYTE_W-1:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/arp_request_reply_resolver_core.sv @@
// ARP next-hop resolver: request generator and reply checker.
//
// Input stream (s_axis): one command per transfer. tuser carries the command
// (start, received byte, timeout), tdata the received byte, tlast the end of
// a received frame. Output stream (m_axis): tuser is the result kind, tdata
// holds the transmit byte and the resolved MAC, tlast ends each run.
// Configuration is written over cfg_* (always ready); the user must do so
// only while the block is idle, which the block itself does not enforce.
//
// Received bytes and timeouts are checked in the cycle they are transferred;
// a received byte that needs no result is taken every cycle unless a request
// frame or an output stall holds it. A single result (resolved or failed)
// appears in the output register in the cycle after the command. A request
// frame is sent out of a byte counter the command starts, one byte per cycle
// while the output is not stalled; s_axis_tready stays low until the last
// frame byte is in the output register. When the receiver stalls, the output
// register holds and s_axis_tready drops. Reset clears configuration,
// receive state and retry count and empties the output register.
`default_nettype none

module arp_request_reply_resolver_core
  import arp_rrr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_A_W-1:0]   cfg_addr_i,
  input  wire logic [MAC_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_D_W-1:0]        m_axis_tdata,   // [7:0] tx_byte, [55:8] resolved_mac
  output logic [KIND_W-1:0]         m_axis_tuser,   // [1:0] kind
  output logic                      m_axis_tlast
);

  logic [MAC_W-1:0]  local_mac_q;
  logic [IP_W-1:0]   local_ip_q, hop_ip_q;
  logic              vlan_en_q, bcast_q;
  logic [VID_W-1:0]  vlan_id_q;

  logic              waiting_q, waiting_d;
  logic [TRY_W-1:0]  try_q, try_d, try_inc;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              good_q, good_d;
  logic [MAC_W-1:0]  src_q, src_d, src_n;
  logic [IP_W-1:0]   pfx_q, pfx_d, pfx_n;
  logic [MAC_W-1:0]  snd_q, snd_d, snd_n;

  logic              tx_busy_q, tx_busy_d;
  logic [POS_W-1:0]  tx_idx_q, tx_idx_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [MAC_W-1:0]  out_mac_q, out_mac_d;

  logic              slot_free, in_fire;
  logic              chk_ok, bad_pos, frame_ok;
  logic [POS_W-1:0]  rj;
  logic [POS_W-1:0]  tj;
  logic [BYTE_W-1:0] tx_b;
  logic              emit_one, start_tx;
  kind_e             emit_kind;
  logic [MAC_W-1:0]  emit_mac;
  cmd_e              cmd;

  assign cfg_ready_o   = 1'b1;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !tx_busy_q && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_mac_q, out_byte_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q <= '0;
      local_ip_q  <= '0;
      hop_ip_q    <= '0;
      vlan_en_q   <= 1'b0;
      vlan_id_q   <= '0;
      bcast_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_LOCAL_MAC:   local_mac_q <= cfg_data_i;
        REG_LOCAL_IP:    local_ip_q  <= cfg_data_i[IP_W-1:0];
        REG_HOP_IP:      hop_ip_q    <= cfg_data_i[IP_W-1:0];
        REG_VLAN_ENABLE: vlan_en_q   <= cfg_data_i[0];
        REG_VLAN_ID:     vlan_id_q   <= cfg_data_i[VID_W-1:0];
        REG_BCAST:       bcast_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Per-byte check of a received frame at the current position.
  always_comb begin
    chk_ok = 1'b1;
    pfx_n  = pfx_q;
    src_n  = src_q;
    snd_n  = snd_q;
    rj     = pos_q - (vlan_en_q ? POS_W'(4) : POS_W'(0));
    if (pos_q < POS_W'(4)) begin
      pfx_n = {pfx_q[IP_W-BYTE_W-1:0], s_axis_tdata};
    end else if (pos_q < POS_W'(6)) begin
      chk_ok = 1'b1;
    end else if (pos_q < POS_W'(12)) begin
      src_n = {src_q[MAC_W-BYTE_W-1:0], s_axis_tdata};
    end else if (vlan_en_q && pos_q < POS_W'(16)) begin
      case (pos_q[1:0])
        2'd0:    chk_ok = (s_axis_tdata == VLAN_TPID_HI);
        2'd1:    chk_ok = (s_axis_tdata == VLAN_TPID_LO);
        2'd2:    chk_ok = (s_axis_tdata == {4'h0, vlan_id_q[11:8]});
        default: chk_ok = (s_axis_tdata == vlan_id_q[7:0]);
      endcase
    end else if (rj < POS_W'(22)) begin
      chk_ok = (s_axis_tdata == REP_HDR[4'(rj - POS_W'(12))]);
    end else if (rj < POS_W'(28)) begin
      snd_n = {snd_q[MAC_W-BYTE_W-1:0], s_axis_tdata};
    end else if (rj < POS_W'(32)) begin
      chk_ok = (s_axis_tdata == ip_byte(hop_ip_q, 2'(rj - POS_W'(28))));
    end else if (rj < POS_W'(38)) begin
      chk_ok = (s_axis_tdata == mac_byte(local_mac_q, 3'(rj - POS_W'(32))));
      if (rj < POS_W'(36) &&
          s_axis_tdata != ip_byte(pfx_q, 2'(rj - POS_W'(32)))) begin
        chk_ok = 1'b0;
      end
    end else if (rj < POS_W'(42)) begin
      chk_ok = (s_axis_tdata == ip_byte(local_ip_q, 2'(rj - POS_W'(38))));
    end
  end

  assign bad_pos  = ({1'b0, pos_q} >= 7'(FRAME_BYTES)) ||
                    (pos_q == '1 && !s_axis_tlast);
  assign try_inc  = try_q + TRY_W'(1);

  // Request frame byte at the generator position.
  always_comb begin
    tx_b = '0;
    tj   = tx_idx_q - (vlan_en_q ? POS_W'(4) : POS_W'(0));
    if (tx_idx_q < POS_W'(6)) begin
      tx_b = 8'hFF;
    end else if (tx_idx_q < POS_W'(12)) begin
      tx_b = mac_byte(local_mac_q, 3'(tx_idx_q - POS_W'(6)));
    end else if (vlan_en_q && tx_idx_q < POS_W'(16)) begin
      case (tx_idx_q[1:0])
        2'd0:    tx_b = VLAN_TPID_HI;
        2'd1:    tx_b = VLAN_TPID_LO;
        2'd2:    tx_b = {4'h0, vlan_id_q[11:8]};
        default: tx_b = vlan_id_q[7:0];
      endcase
    end else if (tj < POS_W'(22)) begin
      tx_b = REQ_HDR[4'(tj - POS_W'(12))];
    end else if (tj < POS_W'(28)) begin
      tx_b = mac_byte(local_mac_q, 3'(tj - POS_W'(22)));
    end else if (tj < POS_W'(32)) begin
      tx_b = ip_byte(local_ip_q, 2'(tj - POS_W'(28)));
    end else if (tj < POS_W'(38)) begin
      tx_b = '0;
    end else if (tj < POS_W'(42)) begin
      tx_b = ip_byte(hop_ip_q, 2'(tj - POS_W'(38)));
    end
  end

  always_comb begin
    waiting_d = waiting_q;
    try_d     = try_q;
    pos_d     = pos_q;
    good_d    = good_q;
    src_d     = src_q;
    pfx_d     = pfx_q;
    snd_d     = snd_q;
    emit_one  = 1'b0;
    emit_kind = KIND_RESOLVED;
    emit_mac  = '0;
    start_tx  = 1'b0;
    frame_ok  = 1'b0;
    if (in_fire) begin
      case (cmd)
        CMD_START: begin
          pos_d  = '0;
          good_d = 1'b1;
          src_d  = '0;
          pfx_d  = '0;
          snd_d  = '0;
          try_d  = '0;
          if (bcast_q) begin
            waiting_d = 1'b0;
            emit_one  = 1'b1;
            emit_mac  = MAC_ONES;
          end else begin
            waiting_d = 1'b1;
            start_tx  = 1'b1;
          end
        end
        CMD_RX_BYTE: begin
          if (waiting_q) begin
            if (bad_pos) begin
              good_d = 1'b0;
            end else begin
              good_d = good_q && chk_ok;
              src_d  = src_n;
              pfx_d  = pfx_n;
              snd_d  = snd_n;
            end
            if (pos_q != '1) pos_d = pos_q + POS_W'(1);
            if (s_axis_tlast) begin
              frame_ok = good_d && ({1'b0, pos_q} + 7'd1 == 7'(FRAME_BYTES)) &&
                         snd_d == src_d && snd_d != '0 && snd_d != MAC_ONES;
              if (frame_ok) begin
                waiting_d = 1'b0;
                emit_one  = 1'b1;
                emit_mac  = src_d;
              end else begin
                start_tx = 1'b1;
              end
              pos_d  = '0;
              good_d = 1'b1;
              src_d  = '0;
              pfx_d  = '0;
              snd_d  = '0;
            end
          end
        end
        CMD_TIMEOUT: begin
          if (waiting_q) begin
            pos_d  = '0;
            good_d = 1'b1;
            src_d  = '0;
            pfx_d  = '0;
            snd_d  = '0;
            try_d  = try_inc;
            if (try_inc >= TRY_W'(MAX_TIMEOUTS)) begin
              waiting_d = 1'b0;
              emit_one  = 1'b1;
              emit_kind = KIND_FAILED;
            end else begin
              start_tx = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame generator and output register.
  always_comb begin
    tx_busy_d   = tx_busy_q;
    tx_idx_d    = tx_idx_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_mac_d   = out_mac_q;
    if (start_tx) begin
      tx_busy_d = 1'b1;
      tx_idx_d  = '0;
    end else if (emit_one) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_byte_d  = '0;
      out_last_d  = 1'b1;
      out_mac_d   = emit_mac;
    end else if (tx_busy_q && slot_free) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_TX_BYTE;
      out_byte_d  = tx_b;
      out_mac_d   = '0;
      out_last_d  = ({1'b0, tx_idx_q} == 7'(FRAME_BYTES - 1));
      if (out_last_d) begin
        tx_busy_d = 1'b0;
      end else begin
        tx_idx_d = tx_idx_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      try_q       <= '0;
      pos_q       <= '0;
      good_q      <= 1'b1;
      src_q       <= '0;
      pfx_q       <= '0;
      snd_q       <= '0;
      tx_busy_q   <= 1'b0;
      tx_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      waiting_q   <= waiting_d;
      try_q       <= try_d;
      pos_q       <= pos_d;
      good_q      <= good_d;
      src_q       <= src_d;
      pfx_q       <= pfx_d;
      snd_q       <= snd_d;
      tx_busy_q   <= tx_busy_d;
      tx_idx_q    <= tx_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_mac_q  <= out_mac_d;
  end

endmodule

`default_nettype wire

@@ sv/arp_rrr_checker.sv @@
// Port-level checks for the ARP resolver and their bind to the resolver core.
`default_nettype none

module arp_rrr_checker
  import arp_rrr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tready,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [OUT_D_W-1:0] m_axis_tdata,
  input wire logic [KIND_W-1:0]  m_axis_tuser,
  input wire logic               m_axis_tlast
);

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_TX_BYTE |-> m_axis_tlast)
    else $error("status result without tlast");

  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_TX_BYTE |-> m_axis_tdata[7:0] == '0)
    else $error("status result carries a tx byte");

  a_fail_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_FAILED |-> m_axis_tdata[55:8] == '0)
    else $error("failure carries a MAC");

  a_frame_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_TX_BYTE && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open in the middle of a request frame");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind arp_request_reply_resolver_core arp_rrr_checker u_arp_rrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
